/* rtl/core/mf35_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the 3/5-tap median filter.
// No dependencies.
package mf35_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int SAMPLE_W       = 32;
   localparam int TAPS           = 5;
   localparam int CELLS          = TAPS - 1;

   // window_mode register codes
   localparam logic MODE_TAP3 = 1'b0;
   localparam logic MODE_TAP5 = 1'b1;

   // job kinds held in the issue mask, bit index = kind
   localparam int JOB_CENTRE = 0;
   localparam int JOB_TAIL1  = 1;
   localparam int JOB_TAIL2  = 2;

   typedef struct packed {
      logic tap3;
      logic eos;
   } mf35_ctl_type;

endpackage

/* rtl/core/mf35_req_if.sv */
`timescale 1ns / 1ps
// Sample input channel: valid/ready plus sample and last.
// Depends on mf35_pkg.
interface mf35_req_if import mf35_pkg::*;;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

/* rtl/core/mf35_rsp_if.sv */
`timescale 1ns / 1ps
// Filtered output channel: valid/ready plus filtered and end_of_segment.
// Depends on mf35_pkg.
interface mf35_rsp_if import mf35_pkg::*;;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] filtered;
   logic                end_of_segment;

   modport source (output valid, output filtered, output end_of_segment, input ready);
   modport sink   (input valid, input filtered, input end_of_segment, output ready);
endinterface

/* rtl/core/mf35_cell.sv */
`timescale 1ns / 1ps
// One window cell: holds a past sample and its filled flag, and forwards
// the edge-replicated tap along the chain. Depends on mf35_pkg.
module mf35_cell import mf35_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  logic                  clear,
   input  logic [DATA_WIDTH-1:0] din,
   input  logic                  vin,
   input  logic [DATA_WIDTH-1:0] tap_in,
   output logic [DATA_WIDTH-1:0] dout,
   output logic                  vout,
   output logic [DATA_WIDTH-1:0] tap_out
);

   logic [DATA_WIDTH-1:0] sample_ff;
   logic                  valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (clear) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= vin;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         sample_ff <= din;
      end
   end

   assign dout    = sample_ff;
   assign vout    = valid_ff;
   // empty slot replicates the segment's first sample from further up
   assign tap_out = valid_ff ? sample_ff : tap_in;

endmodule

/* rtl/core/mf35_median.sv */
`timescale 1ns / 1ps
// Median pipeline: operand register, pairwise compare register, rank
// select into the output register. Depends on mf35_pkg.
module mf35_median import mf35_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [TAPS-1:0][DATA_WIDTH-1:0] in_vals,
   input  mf35_ctl_type                    in_ctl,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [SAMPLE_W-1:0]             out_data,
   output logic                            out_eos
);

   logic                            m1_v_ff;
   logic [TAPS-1:0][DATA_WIDTH-1:0] m1_vals_ff;
   mf35_ctl_type                    m1_ctl_ff;

   logic                            m2_v_ff;
   logic [TAPS-1:0][DATA_WIDTH-1:0] m2_vals_ff;
   logic [TAPS-1:0][TAPS-1:0]       m2_bf_ff;
   logic [TAPS-1:0][TAPS-1:0]       m2_bf_in;
   mf35_ctl_type                    m2_ctl_ff;

   logic                            o_v_ff;
   logic [SAMPLE_W-1:0]             o_data_ff;
   logic [SAMPLE_W-1:0]             o_data_in;
   logic                            o_eos_ff;

   logic o_ready, m2_ready, m1_ready;

   assign o_ready  = !o_v_ff || out_ready;
   assign m2_ready = !m2_v_ff || o_ready;
   assign m1_ready = !m1_v_ff || m2_ready;
   assign in_ready = m1_ready;

   // bf[i][j]: value j ranks before value i (ties broken by slot)
   always_comb begin
      m2_bf_in = '0;
      for (int i = 0; i < TAPS; i++) begin
         for (int j = 0; j < TAPS; j++) begin
            if (j < i) begin
               m2_bf_in[i][j] = (m1_vals_ff[j] <= m1_vals_ff[i]);
            end else if (j > i) begin
               m2_bf_in[i][j] = (m1_vals_ff[j] < m1_vals_ff[i]);
            end
         end
      end
   end

   always_comb begin
      logic [2:0]            rank;
      logic [2:0]            target;
      logic                  hit;
      logic [DATA_WIDTH-1:0] sel;
      sel    = '0;
      target = m2_ctl_ff.tap3 ? 3'd1 : 3'd2;
      for (int i = 0; i < TAPS; i++) begin
         rank = '0;
         for (int j = 0; j < TAPS; j++) begin
            if (!(m2_ctl_ff.tap3 && j > 2)) begin
               rank = rank + 3'(m2_bf_ff[i][j]);
            end
         end
         hit = (rank == target) && !(m2_ctl_ff.tap3 && i > 2);
         sel = sel | (m2_vals_ff[i] & {DATA_WIDTH{hit}});
      end
      o_data_in = SAMPLE_W'(sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         o_v_ff  <= 1'b0;
      end else begin
         if (m1_ready) m1_v_ff <= in_valid;
         if (m2_ready) m2_v_ff <= m1_v_ff;
         if (o_ready)  o_v_ff  <= m2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (m1_ready && in_valid) begin
         m1_vals_ff <= in_vals;
         m1_ctl_ff  <= in_ctl;
      end
      if (m2_ready && m1_v_ff) begin
         m2_vals_ff <= m1_vals_ff;
         m2_bf_ff   <= m2_bf_in;
         m2_ctl_ff  <= m1_ctl_ff;
      end
      if (o_ready && m2_v_ff) begin
         o_data_ff <= o_data_in;
         o_eos_ff  <= m2_ctl_ff.eos;
      end
   end

   assign out_valid = o_v_ff;
   assign out_data  = o_data_ff;
   assign out_eos   = o_eos_ff;

endmodule

/* rtl/core/median_filter_3_or_5_edge_replicate.sv */
`timescale 1ns / 1ps
// Channel  Dir  Beat payload                 Handshake
// req_if   in   sample[31:0], last           valid/ready
// rsp_if   out  filtered[31:0], end_of_seg.  valid/ready
// csr_*    in   window_mode (1 bit)          write enable, no wait
//
// One sample beat per cycle while neither the issue stage nor the median
// pipeline stalls; a last beat holds req ready low while the issue stage
// sends its tail windows (one window per cycle while the median pipeline
// is ready). Each window passes the operand, compare and output registers.
// Synchronous active-high reset clears the window cells, issue stage and
// pipeline valids and sets window_mode to 5-tap. Output stalls back up the
// pipeline stage by stage; empty stages keep filling.
// Depends on mf35_pkg, mf35_req_if, mf35_rsp_if, mf35_cell, mf35_median.
module median_filter_3_or_5_edge_replicate import mf35_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   mf35_req_if.sink         req_if,
   mf35_rsp_if.source       rsp_if,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);

   logic mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TAP5;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   logic                  req_acc;
   logic [DATA_WIDTH-1:0] x;

   assign x       = DATA_WIDTH'(req_if.sample);
   assign req_acc = req_if.valid && req_if.ready;

   // window cell chain, cell 0 newest
   logic [CELLS:0][DATA_WIDTH-1:0] chain_d;
   logic [CELLS:0]                 chain_v;
   logic [CELLS:0][DATA_WIDTH-1:0] chain_tap;

   assign chain_d[0]   = x;
   assign chain_v[0]   = 1'b1;
   assign chain_tap[0] = x;

   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      mf35_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (req_acc && !req_if.last),
         .clear    (req_acc && req_if.last),
         .din      (chain_d[g]),
         .vin      (chain_v[g]),
         .tap_in   (chain_tap[g]),
         .dout     (chain_d[g+1]),
         .vout     (chain_v[g+1]),
         .tap_out  (chain_tap[g+1])
      );
   end

   // b[4] current sample, b[4-d] clamped sample d beats back
   logic [TAPS-1:0][DATA_WIDTH-1:0] b;
   always_comb begin
      for (int d = 0; d < TAPS; d++) begin
         b[TAPS-1-d] = chain_tap[d];
      end
   end

   logic [2:0] new_mask;
   always_comb begin
      new_mask = '0;
      new_mask[JOB_TAIL2] = req_if.last;
      if (mode_ff == MODE_TAP5) begin
         new_mask[JOB_TAIL1]  = req_if.last && chain_v[1];
         new_mask[JOB_CENTRE] = chain_v[2];
      end else begin
         new_mask[JOB_CENTRE] = chain_v[1];
      end
   end

   // issue stage
   logic [TAPS-1:0][DATA_WIDTH-1:0] s_b_ff;
   logic [2:0]                      s_mask_ff;
   logic [2:0]                      s_mask_in;
   logic                            s_tap3_ff;
   logic [2:0]                      s_pick;
   logic                            s_issue;
   logic                            s_single;
   logic                            m_ready;
   logic [TAPS-1:0][DATA_WIDTH-1:0] job_vals;
   mf35_ctl_type                    job_ctl;

   assign s_pick   = s_mask_ff & (~s_mask_ff + 3'd1);
   assign s_single = (s_mask_ff & (s_mask_ff - 3'd1)) == 3'd0;
   assign s_issue  = (s_mask_ff != 3'd0) && m_ready;
   assign req_if.ready = (s_mask_ff == 3'd0) || (s_issue && s_single);

   always_comb begin
      if (req_acc) begin
         s_mask_in = new_mask;
      end else if (s_issue) begin
         s_mask_in = s_mask_ff & ~s_pick;
      end else begin
         s_mask_in = s_mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_mask_ff <= '0;
      end else begin
         s_mask_ff <= s_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s_b_ff    <= b;
         s_tap3_ff <= (mode_ff == MODE_TAP3);
      end
   end

   always_comb begin
      job_ctl.tap3 = s_tap3_ff;
      job_ctl.eos  = s_pick[JOB_TAIL2];
      job_vals     = {TAPS{s_b_ff[4]}};
      if (s_pick[JOB_CENTRE]) begin
         if (s_tap3_ff) begin
            job_vals[0] = s_b_ff[2];
            job_vals[1] = s_b_ff[3];
         end else begin
            job_vals = s_b_ff;
         end
      end else if (s_pick[JOB_TAIL1]) begin
         job_vals[0] = s_b_ff[1];
         job_vals[1] = s_b_ff[2];
         job_vals[2] = s_b_ff[3];
      end else begin
         if (s_tap3_ff) begin
            job_vals[0] = s_b_ff[3];
         end else begin
            job_vals[0] = s_b_ff[2];
            job_vals[1] = s_b_ff[3];
         end
      end
   end

   mf35_median #(.DATA_WIDTH(DATA_WIDTH)) u_median (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_mask_ff != 3'd0),
      .in_ready  (m_ready),
      .in_vals   (job_vals),
      .in_ctl    (job_ctl),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (rsp_if.filtered),
      .out_eos   (rsp_if.end_of_segment)
   );

endmodule
